[hdl/rlcg_pkg.sv]
`timescale 1ns / 1ps

package rlcg_pkg;

  localparam logic [1:0]  FUNC_DRAW   = 2'd0;
  localparam logic [1:0]  FUNC_RESEED = 2'd1;
  localparam logic [1:0]  FUNC_RESET  = 2'd2;

  localparam logic [31:0] LCG_MULT  = 32'd1103515245;
  localparam logic [63:0] LCG_INC   = 64'd12345;
  localparam int          LCG_SHIFT = 16;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] range_limit;
    logic [63:0] seed_value;
  } rlcg_in_t;

  typedef struct packed {
    logic [31:0] value;
    logic [63:0] seed_now;
    logic [31:0] draw_count;
    logic [31:0] reseed_total;
  } rlcg_out_t;

  typedef struct packed {
    logic        en;
    logic [31:0] op_a;
    logic [31:0] op_b;
  } rlcg_mul_req_t;

endpackage

[hdl/rlcg_mul.sv]
`timescale 1ns / 1ps

module rlcg_mul
  import rlcg_pkg::*;
(
  input  logic          clk,
  input  rlcg_mul_req_t req,
  output logic [63:0]   prod
);

  logic [63:0] prod_r;
  logic [63:0] prod_nxt;

  assign prod_nxt = req.op_a * req.op_b;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

[hdl/ranged_lcg_generator_core.sv]
`timescale 1ns / 1ps

// Ranged 64-bit LCG. One transaction in, one result out. A draw with a range
// of 2 or more advances the seed (seed*1103515245+12345 mod 2^64) and returns
// the top word of seed[47:16]*range; it uses a single registered 32x32
// multiplier three times (low seed half, high seed half, range scaling) plus
// one high-word add, passing S_MLO, S_MHI, S_ADD and S_MRNG before S_FIN
// registers the result. Trivial draws, reseeds and resets go straight to
// S_FIN. The input stalls while a transaction is in flight (no new one until
// the last commits); a held result stalls only the final step.
module ranged_lcg_generator_core
  import rlcg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rlcg_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output rlcg_out_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MLO  = 3'd1;
  localparam logic [2:0] S_MHI  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_MRNG = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  rlcg_in_t      item_r;
  logic [63:0]   acc_r, acc_nxt;
  logic [63:0]   seed_r, seed_nxt;
  logic [31:0]   draw_cnt_r, draw_cnt_nxt;
  logic [31:0]   reseed_cnt_r, reseed_cnt_nxt;
  logic [31:0]   value_nxt;
  logic          out_valid_r;
  rlcg_out_t     out_data_r;
  rlcg_mul_req_t mul_req;
  logic [63:0]   prod;
  logic          in_acc;
  logic          commit;
  logic          item_draw;

  rlcg_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign commit    = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign item_draw = (item_r.func == FUNC_DRAW) && (|item_r.range_limit[31:1]);

  always_comb begin
    mul_req = '0;
    case (state_r)
      S_MLO: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = seed_r[31:0];
        mul_req.op_b = LCG_MULT;
      end
      S_MHI: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = seed_r[63:32];
        mul_req.op_b = LCG_MULT;
      end
      S_MRNG: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = acc_r[LCG_SHIFT +: 32];
        mul_req.op_b = item_r.range_limit;
      end
      default: mul_req = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_data.func == FUNC_DRAW) && (|in_data.range_limit[31:1])) begin
            state_nxt = S_MLO;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_MLO:  state_nxt = S_MHI;
      S_MHI: begin
        acc_nxt   = prod + LCG_INC;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        acc_nxt   = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
        state_nxt = S_MRNG;
      end
      S_MRNG: state_nxt = S_FIN;
      S_FIN: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    value_nxt      = '0;
    seed_nxt       = seed_r;
    draw_cnt_nxt   = draw_cnt_r;
    reseed_cnt_nxt = reseed_cnt_r;
    case (item_r.func)
      FUNC_DRAW: begin
        if (item_draw) begin
          value_nxt    = prod[63:32];
          seed_nxt     = acc_r;
          draw_cnt_nxt = draw_cnt_r + 32'd1;
        end
      end
      FUNC_RESEED: begin
        seed_nxt       = item_r.seed_value;
        reseed_cnt_nxt = reseed_cnt_r + 32'd1;
      end
      FUNC_RESET: begin
        if (item_r.seed_value != seed_r) begin
          seed_nxt       = item_r.seed_value;
          reseed_cnt_nxt = reseed_cnt_r + 32'd1;
        end
        draw_cnt_nxt = '0;
      end
      default: value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      seed_r       <= '0;
      draw_cnt_r   <= '0;
      reseed_cnt_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        seed_r       <= seed_nxt;
        draw_cnt_r   <= draw_cnt_nxt;
        reseed_cnt_r <= reseed_cnt_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    acc_r <= acc_nxt;
    if (commit) begin
      out_data_r.value        <= value_nxt;
      out_data_r.seed_now     <= seed_nxt;
      out_data_r.draw_count   <= draw_cnt_nxt;
      out_data_r.reseed_total <= reseed_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_draw_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.func == FUNC_DRAW) && (|in_data.range_limit[31:1]))
    |=> (state_r == S_MLO))
    else $error("nontrivial draw did not start the multiply sequence");

  a_value_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && item_draw) |=> (out_data_r.value < item_r.range_limit))
    else $error("drawn value not below range");

  a_seed_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(seed_r))
    else $error("seed changed outside a commit");

  a_trivial_no_output_value: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !item_draw) |=> (out_data_r.value == 32'd0))
    else $error("non-draw transaction returned a nonzero value");

endmodule
